[design/rwm_pkg.sv]
package rwm_pkg;

    // Field and state widths
    localparam int SAMPLE_BITS   = 10;
    localparam int SQ_BITS       = 2 * SAMPLE_BITS;
    localparam int SUM_BITS      = 30;
    localparam int CNT_BITS      = 10;
    localparam int Q4_BITS       = 14;
    localparam int MV_BITS       = 16;

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FULL_SCALE_MV = 2'd1;
    localparam logic [CNT_BITS-1:0]      WINDOW_RESET      = 10'd100;
    localparam logic [MV_BITS-1:0]       FULL_SCALE_RESET  = 16'd5000;

    // Arithmetic constants
    localparam logic [SUM_BITS-1:0] SUM_MAX      = '1;
    localparam int                  CODE_SQ_BITS = 20;
    localparam logic [CODE_SQ_BITS-1:0] CODE_FULL_SQ = 20'd1046529;  // 1023 * 1023
    localparam logic [Q4_BITS-1:0]  Q4_MAX       = '1;
    localparam logic [MV_BITS-1:0]  MV_MAX       = '1;

    // Shared divide / square-root unit
    localparam int NUM_BITS   = 62;
    localparam int DEN_BITS   = 30;
    localparam int QUO_BITS   = 32;
    localparam int STEP_BITS  = 5;
    localparam int DIV_STEPS  = 32;
    localparam int SQRT_STEPS = 16;
    localparam int MUL_BITS   = 32;

    typedef enum logic [0:0] {
        DS_DIV,
        DS_SQRT
    } t_ds_op;

    typedef struct packed {
        logic   start;
        t_ds_op op;
    } t_ds_ctl;

    typedef struct packed {
        logic load;
        logic add;
        logic clear;
    } t_acc_ctl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_CHECK,
        ST_DIV_Q4,
        ST_SQRT_Q4,
        ST_MUL_FS2,
        ST_MUL_NUM,
        ST_MUL_DEN,
        ST_DIV_MV,
        ST_SQRT_MV,
        ST_DONE
    } t_state;

endpackage

[design/rms_window_meter_core.sv]
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+----------------------------------
// sample in | input     | i_in_valid / o_in_ready   | i_sample[9:0]
// result    | output    | o_out_valid / i_out_ready | o_rms_code_q4[13:0],
//           |           |                           | o_rms_millivolts[15:0]
// config    | input     | i_cfg_valid / o_cfg_ready | i_cfg_index[1:0], i_cfg_data[15:0]
//
// A sample that does not close its window is taken, squared, added and checked.
// The sample that closes a window then runs two 32-step divides
// and two 16-step roots in the shared divide / square-root unit, three multiplies.
// Reset (synchronous, active low) clears the count, the sum and the result beat; the
// registers return to 100 samples and 5000 mV. A stalled result holds in the output
// register; the next window runs meanwhile and waits only if it finishes first.
module rms_window_meter_core import rwm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [SAMPLE_BITS-1:0]   i_sample,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [Q4_BITS-1:0]       o_rms_code_q4,
    output logic [MV_BITS-1:0]       o_rms_millivolts,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [CNT_BITS-1:0] r_win_len;
    logic [MV_BITS-1:0]  r_fs_mv;
    logic                r_started;
    logic [QUO_BITS-1:0] r_fs2;
    logic [NUM_BITS-1:0] r_num;
    logic [DEN_BITS-1:0] r_den;
    logic [Q4_BITS-1:0]  r_q4_res;
    logic                r_out_valid;
    logic [Q4_BITS-1:0]  r_out_q4;
    logic [MV_BITS-1:0]  r_out_mv;

    t_acc_ctl            acc_ctl;
    t_ds_ctl             ds_ctl;
    logic                ds_run;
    logic                out_load;
    logic                ds_done;
    logic [QUO_BITS-1:0] ds_result;
    logic [NUM_BITS-1:0] ds_dividend;
    logic [DEN_BITS-1:0] ds_divisor;
    logic [SUM_BITS-1:0] acc_sum;
    logic [CNT_BITS-1:0] acc_count;
    logic [CNT_BITS-1:0] eff_len;
    logic [MUL_BITS-1:0] mul_a;
    logic [MUL_BITS-1:0] mul_b;
    logic [2*MUL_BITS-1:0] mul_prod;

    rwm_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (acc_ctl),
        .i_sample (i_sample),
        .o_sum    (acc_sum),
        .o_count  (acc_count)
    );

    rwm_divsqrt u_divsqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ds_ctl),
        .i_dividend (ds_dividend),
        .i_divisor  (ds_divisor),
        .o_done     (ds_done),
        .o_result   (ds_result)
    );

    // Configuration writes only between samples; unknown indexes drop
    assign o_cfg_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= WINDOW_RESET;
            r_fs_mv   <= FULL_SCALE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WINDOW_LENGTH: r_win_len <= i_cfg_data[CNT_BITS-1:0];
                CFG_FULL_SCALE_MV: r_fs_mv   <= i_cfg_data[MV_BITS-1:0];
                default: ;
            endcase
        end
    end

    // A zero window length acts as one sample
    assign eff_len = (r_win_len == '0) ? CNT_BITS'(1) : r_win_len;

    // Shared multiplier operands
    always_comb begin
        case (r_state)
            ST_MUL_FS2: begin
                mul_a = {{(MUL_BITS - MV_BITS){1'b0}}, r_fs_mv};
                mul_b = {{(MUL_BITS - MV_BITS){1'b0}}, r_fs_mv};
            end
            ST_MUL_NUM: begin
                mul_a = {{(MUL_BITS - SUM_BITS){1'b0}}, acc_sum};
                mul_b = r_fs2;
            end
            ST_MUL_DEN: begin
                mul_a = {{(MUL_BITS - CNT_BITS){1'b0}}, acc_count};
                mul_b = {{(MUL_BITS - CODE_SQ_BITS){1'b0}}, CODE_FULL_SQ};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // Divide / root operands
    always_comb begin
        case (r_state)
            ST_DIV_Q4: begin
                ds_dividend = {{(NUM_BITS - SUM_BITS - 8){1'b0}}, acc_sum, 8'h00};
                ds_divisor  = {{(DEN_BITS - CNT_BITS){1'b0}}, acc_count};
            end
            ST_DIV_MV: begin
                ds_dividend = r_num;
                ds_divisor  = r_den;
            end
            default: begin
                ds_dividend = {{(NUM_BITS - QUO_BITS){1'b0}}, ds_result};
                ds_divisor  = r_den;
            end
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        acc_ctl    = '0;
        ds_run     = 1'b0;
        ds_ctl.op  = DS_DIV;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    acc_ctl.load = 1'b1;
                    n_state      = ST_ACC;
                end
            end
            ST_ACC: begin
                acc_ctl.add = 1'b1;
                n_state     = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = (acc_count >= eff_len) ? ST_DIV_Q4 : ST_IDLE;
            end
            ST_DIV_Q4: begin
                ds_run = 1'b1;
                if (ds_done) begin
                    n_state = ST_SQRT_Q4;
                end
            end
            ST_SQRT_Q4: begin
                ds_run    = 1'b1;
                ds_ctl.op = DS_SQRT;
                if (ds_done) begin
                    n_state = ST_MUL_FS2;
                end
            end
            ST_MUL_FS2: n_state = ST_MUL_NUM;
            ST_MUL_NUM: n_state = ST_MUL_DEN;
            ST_MUL_DEN: n_state = ST_DIV_MV;
            ST_DIV_MV: begin
                ds_run = 1'b1;
                if (ds_done) begin
                    n_state = ST_SQRT_MV;
                end
            end
            ST_SQRT_MV: begin
                ds_run    = 1'b1;
                ds_ctl.op = DS_SQRT;
                if (ds_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load      = 1'b1;
                    acc_ctl.clear = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        ds_ctl.start = ds_run && !r_started;
    end

    // Issue each divide or root once per state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
        end else if (ds_done) begin
            r_started <= 1'b0;
        end else if (ds_ctl.start) begin
            r_started <= 1'b1;
        end
    end

    // Hold products and the code result, saturating the root
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_MUL_FS2: r_fs2 <= mul_prod[QUO_BITS-1:0];
            ST_MUL_NUM: r_num <= mul_prod[NUM_BITS-1:0];
            ST_MUL_DEN: r_den <= mul_prod[DEN_BITS-1:0];
            ST_SQRT_Q4: begin
                if (ds_done) begin
                    r_q4_res <= (ds_result > {{(QUO_BITS - Q4_BITS){1'b0}}, Q4_MAX})
                                ? Q4_MAX : ds_result[Q4_BITS-1:0];
                end
            end
            default: ;
        endcase
    end

    // Result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_q4 <= r_q4_res;
            r_out_mv <= (ds_result > {{(QUO_BITS - MV_BITS){1'b0}}, MV_MAX})
                        ? MV_MAX : ds_result[MV_BITS-1:0];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_rms_code_q4    = r_out_q4;
    assign o_rms_millivolts = r_out_mv;

endmodule

[design/rwm_accum.sv]
module rwm_accum import rwm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_acc_ctl               i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic [SUM_BITS-1:0]    o_sum,
    output logic [CNT_BITS-1:0]    o_count
);

    logic [SQ_BITS-1:0]  r_sq;
    logic [SUM_BITS-1:0] r_sum;
    logic [CNT_BITS-1:0] r_count;
    logic [SUM_BITS:0]   sum_wide;

    // Saturating add of the registered square
    assign sum_wide = {1'b0, r_sum} + {{(SUM_BITS + 1 - SQ_BITS){1'b0}}, r_sq};

    // Square the sample as it is taken
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_sq <= i_sample * i_sample;
        end
    end

    // Advance sum and count, drop both at window end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_ctl.add) begin
            r_sum   <= sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
            r_count <= r_count + 1'b1;
        end
    end

    assign o_sum   = r_sum;
    assign o_count = r_count;

endmodule

[design/rwm_divsqrt.sv]
module rwm_divsqrt import rwm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ds_ctl             i_ctl,
    input  logic [NUM_BITS-1:0] i_dividend,
    input  logic [DEN_BITS-1:0] i_divisor,
    output logic                o_done,
    output logic [QUO_BITS-1:0] o_result
);

    logic                 r_busy;
    logic                 r_done;
    t_ds_op               r_op;
    logic [STEP_BITS-1:0] r_cnt;
    logic [QUO_BITS-1:0]  r_rem;
    logic [QUO_BITS-1:0]  r_work;
    logic [QUO_BITS-1:0]  r_quo;
    logic [DEN_BITS-1:0]  r_den;

    logic [QUO_BITS-1:0]  sub_a;
    logic [QUO_BITS-1:0]  sub_b;
    logic [QUO_BITS:0]    diff;
    logic                 fits;

    // Pick the trial operands: one divide bit or one root bit per step
    always_comb begin
        case (r_op)
            DS_DIV: begin
                sub_a = {r_rem[QUO_BITS-2:0], r_work[QUO_BITS-1]};
                sub_b = {{(QUO_BITS - DEN_BITS){1'b0}}, r_den};
            end
            DS_SQRT: begin
                sub_a = {r_rem[QUO_BITS-3:0], r_work[QUO_BITS-1:QUO_BITS-2]};
                sub_b = {r_quo[QUO_BITS-3:0], 2'b01};
            end
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    // Shared subtract and compare
    assign diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign fits = !diff[QUO_BITS];

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= DS_DIV;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_op   <= i_ctl.op;
                r_cnt  <= (i_ctl.op == DS_DIV) ? STEP_BITS'(DIV_STEPS - 1)
                                                : STEP_BITS'(SQRT_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient is known to fit in the low word, so the upper
    // dividend bits seed the partial remainder and only those steps run
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo  <= '0;
            r_den  <= i_divisor;
            r_work <= i_dividend[QUO_BITS-1:0];
            if (i_ctl.op == DS_DIV) begin
                r_rem <= {{(2 * QUO_BITS - NUM_BITS){1'b0}}, i_dividend[NUM_BITS-1:QUO_BITS]};
            end else begin
                r_rem <= '0;
            end
        end else if (r_busy) begin
            r_rem <= fits ? diff[QUO_BITS-1:0] : sub_a;
            r_quo <= {r_quo[QUO_BITS-2:0], fits};
            if (r_op == DS_DIV) begin
                r_work <= {r_work[QUO_BITS-2:0], 1'b0};
            end else begin
                r_work <= {r_work[QUO_BITS-3:0], 2'b00};
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_quo;

endmodule

[tb/sv/rms_window_meter_core_tb.sv]
module rms_window_meter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rwm_pkg::*;

    localparam int          MAX_WINDOW     = 1023;
    localparam longint unsigned FULL_CODE  = 1023;
    localparam int          RANDOM_ITEMS   = 1750;
    localparam int          IDLE_PCT       = 19;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          DRAIN_CYCLES   = 150;

    // Indexes past the register map; writes there must change nothing
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [Q4_BITS-1:0] q4;
        logic [MV_BITS-1:0] mv;
    } t_rms_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [SAMPLE_BITS-1:0]   i_sample = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [Q4_BITS-1:0]       o_rms_code_q4;
    logic [MV_BITS-1:0]       o_rms_millivolts;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    // Predictor copy of the registers and the running window
    logic [CNT_BITS-1:0] window_reg     = WINDOW_RESET;
    logic [MV_BITS-1:0]  full_scale_reg = FULL_SCALE_RESET;
    logic [CNT_BITS-1:0] win_count      = '0;
    logic [SUM_BITS-1:0] win_sum        = '0;

    logic [SAMPLE_BITS-1:0] sample_backlog[$];
    t_rms_result            rms_expected[$];

    logic sample_taken = 1'b0;
    logic steady       = 1'b0;
    int   errors          = 0;
    int   samples_fed     = 0;
    int   windows_checked = 0;
    int   reg_writes      = 0;
    int   stall_cycles    = 0;

    rms_window_meter_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sample         (i_sample),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_rms_code_q4    (o_rms_code_q4),
        .o_rms_millivolts (o_rms_millivolts),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Floor square root, one result bit per pass from the top
    function automatic longint unsigned root_floor(input longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_BITS-1:0] idx,
                                            input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_WINDOW_LENGTH: begin
                window_reg = data[CNT_BITS-1:0];
            end
            CFG_FULL_SCALE_MV: begin
                full_scale_reg = data[MV_BITS-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    // Fold one sample into the window; close it and queue the RMS when full
    function automatic void absorb_sample(input logic [SAMPLE_BITS-1:0] s);
        longint unsigned len;
        longint unsigned n;
        longint unsigned sum;
        longint unsigned fs;
        longint unsigned q4;
        longint unsigned mv;
        t_rms_result     res;
        len = window_reg;
        if (len == 0) len = 1;
        if (len > MAX_WINDOW) len = MAX_WINDOW;
        sum = longint'(win_sum) + longint'(s) * longint'(s);
        if (sum > SUM_MAX) sum = SUM_MAX;
        n = longint'(win_count) + 1;
        if (n < len) begin
            win_sum   = sum[SUM_BITS-1:0];
            win_count = n[CNT_BITS-1:0];
            return;
        end
        fs = full_scale_reg;
        q4 = root_floor((sum << 8) / n);
        if (q4 > Q4_MAX) q4 = Q4_MAX;
        mv = root_floor((sum * fs * fs) / (n * FULL_CODE * FULL_CODE));
        if (mv > MV_MAX) mv = MV_MAX;
        res.q4 = q4[Q4_BITS-1:0];
        res.mv = mv[MV_BITS-1:0];
        rms_expected.push_back(res);
        win_sum   = '0;
        win_count = '0;
    endfunction

    // Mix of rails, near-full-scale codes and uniform codes
    function automatic logic [SAMPLE_BITS-1:0] draw_sample();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10) return '0;
        if (pick < 20) return '1;
        if (pick < 35) return SAMPLE_BITS'($urandom_range(1023, 990));
        return SAMPLE_BITS'($urandom);
    endfunction

    // Sample source: hold the beat until taken, then advance or idle
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || sample_taken)) begin
            if (sample_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                i_in_valid <= 1'b1;
                i_sample   <= sample_backlog.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Observe every channel at the edge, predict and check results
    always @(posedge i_clk) begin : observe
        t_rms_result got;
        t_rms_result want;
        logic        moved;
        moved        = 1'b0;
        sample_taken = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_reg_write(i_cfg_index, i_cfg_data);
                reg_writes++;
                moved = 1'b1;
            end
            if (i_in_valid && o_in_ready) begin
                absorb_sample(i_sample);
                samples_fed++;
                sample_taken = 1'b1;
                moved        = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                moved  = 1'b1;
                got.q4 = o_rms_code_q4;
                got.mv = o_rms_millivolts;
                if (rms_expected.size() == 0) begin
                    errors++;
                    $display("%0t: result beat q4=%0d mv=%0d with no window closed",
                             $time, got.q4, got.mv);
                end else begin
                    want = rms_expected.pop_front();
                    windows_checked++;
                    if (got.q4 !== want.q4) begin
                        errors++;
                        $display("%0t: rms_code_q4 expected %0d, got %0d",
                                 $time, want.q4, got.q4);
                    end
                    if (got.mv !== want.mv) begin
                        errors++;
                        $display("%0t: rms_millivolts expected %0d, got %0d",
                                 $time, want.mv, got.mv);
                    end
                end
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat on any channel for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Hold the register beat until the block takes it; valid stays up
    task automatic reg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic reg_release();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every sample is taken and every window result is back
    task automatic settle();
        while (sample_backlog.size() != 0 || i_in_valid || rms_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned pick;
        int          len;
        int          nwin;
        int          count;
        int          phase;
        int          random_fed;
        logic [CNT_BITS-1:0] win_field;
        logic [MV_BITS-1:0]  fs_field;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Open a window under the reset registers with rail and checker codes
        sample_backlog = '{10'd1023, 10'd0, 10'd1, 10'd512, 10'h155, 10'h2AA};
        settle();

        // Shorten the window below the count: the next sample closes it
        reg_write(CFG_WINDOW_LENGTH, 16'd3);
        reg_release();
        sample_backlog.push_back(10'd1023);
        settle();

        // Full-scale codes at the widest full scale
        reg_write(CFG_FULL_SCALE_MV, 16'hFFFF);
        reg_release();
        sample_backlog = '{10'd1023, 10'd1023, 10'd1023};
        settle();

        // Length field of zero means one sample; zero full scale; spare indexes
        reg_write(CFG_WINDOW_LENGTH, 16'h0400);
        reg_write(CFG_FULL_SCALE_MV, 16'd0);
        reg_write(CFG_SPARE_A, 16'hFFFF);
        reg_write(CFG_SPARE_B, 16'h5A5A);
        reg_release();
        sample_backlog = '{10'd1023, 10'd0, 10'd777};
        settle();

        reg_write(CFG_WINDOW_LENGTH, 16'd1);
        reg_write(CFG_FULL_SCALE_MV, 16'd1);
        reg_release();
        sample_backlog = '{10'd1023, 10'd1};
        settle();

        // Random phases: new registers, whole windows, often a partial tail
        phase      = 0;
        random_fed = 0;
        while (random_fed < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (phase == 2) len = MAX_WINDOW;
            else if (pick < 50) len = $urandom_range(8, 1);
            else if (pick < 92) len = $urandom_range(40, 9);
            else len = $urandom_range(200, 41);
            win_field = ($urandom_range(19) == 0 && phase != 2) ? '0 : CNT_BITS'(len);
            if (win_field == 0) len = 1;
            steady = (phase >= 4 && phase < 9);

            if (phase == 2 || $urandom_range(9) != 0)
                reg_write(CFG_WINDOW_LENGTH, {6'($urandom), win_field});
            if ($urandom_range(9) < 7) begin
                pick = $urandom_range(99);
                if (pick < 10) fs_field = 16'd1;
                else if (pick < 20) fs_field = 16'hFFFF;
                else if (pick < 25) fs_field = 16'd0;
                else if (pick < 35) fs_field = FULL_SCALE_RESET;
                else fs_field = 16'($urandom);
                reg_write(CFG_FULL_SCALE_MV, fs_field);
            end
            if ($urandom_range(9) == 0)
                reg_write($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));
            reg_release();

            if (len == MAX_WINDOW) nwin = 1;
            else if (len <= 8) nwin = $urandom_range(40, 5);
            else nwin = $urandom_range(4, 1);
            count = nwin * len + ($urandom_range(1) ? $urandom_range(len - 1, 0) : 0);
            for (int k = 0; k < count; k++) begin
                if (phase == 2 && $urandom_range(9) != 0) sample_backlog.push_back('1);
                else sample_backlog.push_back(draw_sample());
            end
            random_fed += count;
            settle();
            phase++;
        end
        steady = 1'b0;

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Fed %0d samples over %0d random phases; checked %0d window results.",
                 samples_fed, phase, windows_checked);
        $display("Made %0d register writes; windows ran from 1 to %0d samples.",
                 reg_writes, MAX_WINDOW);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
